// ----- src/tag_nesting_conflict_counter_top_assert.svh -----
// ----------------------------------------------------------------------------
// Tag nesting conflict counter: assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef TAG_NESTING_CONFLICT_COUNTER_TOP_ASSERT_SVH
`define TAG_NESTING_CONFLICT_COUNTER_TOP_ASSERT_SVH

// check while out of reset
`define TNCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check at every edge, reset included
`define TNCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- src/tncc_pkg.sv -----
// ----------------------------------------------------------------------------
// Tag nesting conflict counter package
// Sizes, stack shift codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tncc_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned TagBits    = 16;
  localparam int unsigned CodeBits   = 16;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned DepthBits  = $clog2(StackDepth + 1);

  typedef logic [TagBits-1:0]   tag_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [DepthBits-1:0] depth_t;

  typedef enum logic [1:0] {
    OpHold = 2'd0,
    OpPush = 2'd1,
    OpPop1 = 2'd2,
    OpPop2 = 2'd3
  } stk_op_e;

endpackage

`default_nettype wire

// ----- src/tag_nesting_conflict_counter_top.sv -----
// ----------------------------------------------------------------------------
// Tag nesting conflict counter
// Checks tag nesting over a stream of tags and counts nesting conflicts.
// ----------------------------------------------------------------------------
// The block returns the result beat for each tag beat in the next cycle from
// an output register; the input stays ready while that register is empty or
// being drained, so the sustained rate is one beat per cycle unless the output
// stalls. The open-tag stack is a chain of StackDepth cells that shift one or
// two places per beat, so only the top two cells are ever compared, and the
// depth and count update in the same cycle. Stack contents need no clearing
// after reset; the block is ready as soon as reset is released.
`default_nettype none

module tag_nesting_conflict_counter_top
  import tncc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [CodeBits-1:0]  s_axis_tdata,  // [15:0] tag_code
  input  wire logic [1:0]           s_axis_tuser,  // [0] is_closing, [1] tag_valid
  input  wire logic                 s_axis_tlast,  // is_last
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [CountBits-1:0]      m_axis_tdata,  // [15:0] conflict_count
  output logic                      m_axis_tuser,  // [0] overflow
  output logic                      m_axis_tlast   // done_res
);

  tag_t    chain [StackDepth+2];
  stk_op_e op;

  tncc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .top0_i        (chain[0]),
    .top1_i        (chain[1]),
    .op_o          (op)
  );

  assign chain[StackDepth]   = '0;
  assign chain[StackDepth+1] = '0;

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    tag_t prev;
    if (i == 0) begin : g_top
      assign prev = s_axis_tdata[TagBits-1:0];
    end else begin : g_mid
      assign prev = chain[i-1];
    end
    tncc_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .prev_i  (prev),
      .next_i  (chain[i+1]),
      .next2_i (chain[i+2]),
      .entry_o (chain[i])
    );
  end

endmodule

`default_nettype wire

// ----- src/tncc_cell.sv -----
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the shift stack; takes the entry above on a push and the
// entry one or two below on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module tncc_cell
  import tncc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire stk_op_e op_i,
  input  wire tag_t    prev_i,
  input  wire tag_t    next_i,
  input  wire tag_t    next2_i,
  output tag_t         entry_o
);

  tag_t entry_q;
  tag_t entry_d;

  always_comb begin
    case (op_i)
      OpPush:  entry_d = prev_i;
      OpPop1:  entry_d = next_i;
      OpPop2:  entry_d = next2_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- src/tncc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Stack and count control
// Decodes each beat against the top two entries, keeps depth and the
// saturating count, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tncc_ctrl
  import tncc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [CodeBits-1:0] s_axis_tdata,
  input  wire logic [1:0]          s_axis_tuser,
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [CountBits-1:0]     m_axis_tdata,
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast,
  input  wire tag_t                top0_i,
  input  wire tag_t                top1_i,
  output stk_op_e                  op_o
);

  localparam int unsigned SumBits = CountBits + 1;

  depth_t  depth_q;
  depth_t  depth_d;
  count_t  count_q;
  count_t  count_d;
  logic    out_valid_q;
  count_t  out_count_q;
  logic    out_last_q;
  logic    out_ovf_q;

  tag_t                 tag;
  logic                 closing;
  logic                 tag_valid;
  logic                 accept;
  logic                 inc;
  logic                 ovf;
  stk_op_e              op;
  depth_t               depth_n;
  logic [SumBits-1:0]   sum;
  count_t               sat;

  assign tag       = s_axis_tdata[TagBits-1:0];
  assign closing   = s_axis_tuser[0];
  assign tag_valid = s_axis_tuser[1];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    op      = OpHold;
    inc     = 1'b0;
    ovf     = 1'b0;
    depth_n = depth_q;
    if (tag_valid) begin
      if (closing) begin
        if (depth_q == '0) begin
          inc = 1'b1;
        end else if (top0_i == tag) begin
          op      = OpPop1;
          depth_n = depth_q - depth_t'(1);
        end else begin
          inc = 1'b1;
          if (depth_q > depth_t'(1) && top1_i == tag) begin
            op      = OpPop2;
            depth_n = depth_q - depth_t'(2);
          end
        end
      end else begin
        if (depth_q != depth_t'(StackDepth)) begin
          op      = OpPush;
          depth_n = depth_q + depth_t'(1);
        end else begin
          inc = 1'b1;
          ovf = 1'b1;
        end
      end
    end
  end

  // count + increment + final depth, saturated once
  assign sum = {1'b0, count_q} + SumBits'(inc)
             + (s_axis_tlast ? SumBits'(depth_n) : SumBits'(0));
  assign sat = sum[SumBits-1] ? '1 : sum[CountBits-1:0];

  assign depth_d = s_axis_tlast ? '0 : depth_n;
  assign count_d = s_axis_tlast ? '0 : sat;

  assign op_o = accept ? op : OpHold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        depth_q     <= depth_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_count_q <= sat;
      out_last_q  <= s_axis_tlast;
      out_ovf_q   <= ovf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_count_q;
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- src/tncc_checker.sv -----
// ----------------------------------------------------------------------------
// Tag nesting conflict counter checker
// Port-level checks on the result register and the stream handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tag_nesting_conflict_counter_top_assert.svh"

module tncc_checker
  import tncc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [CountBits-1:0] m_axis_tdata,
  input wire logic                m_axis_tuser,
  input wire logic                m_axis_tlast
);

  `TNCC_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |-> !m_axis_tvalid, "result beat during reset")

  `TNCC_ASSERT(a_in_gives_out, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "beat lost")

  `TNCC_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "stall with empty output")

  `TNCC_ASSERT(a_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")

  `TNCC_ASSERT(a_data_holds, m_axis_tvalid && !m_axis_tready |=>
               $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
               "stalled beat changed")

endmodule

bind tag_nesting_conflict_counter_top tncc_checker u_tncc_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Tag nesting conflict counter testbench
// Drives tag beats into the counter and checks every result beat against a
// fixed table entry or an in-bench model of the open-tag stack and the
// saturating conflict count. A short table of directed beats comes first.
// Random documents follow, most of them well nested and some of them
// filling the stack, while both sides idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tncc_pkg::*;

  typedef struct packed {
    logic [CodeBits-1:0] code;
    logic                closing;
    logic                valid;
    logic                last;
  } tag_beat_t;

  typedef struct packed {
    count_t count;
    logic   done;
    logic   ovf;
  } tag_result_t;

  typedef struct packed {
    tag_beat_t   beat;
    logic        fixed;
    tag_result_t res;
  } dir_row_t;

  localparam int unsigned NumDirRows = 23;
  localparam int unsigned CountMax   = 65535;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{'{16'hFFFF, 1'b1, 1'b0, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b1, '{16'd1, 1'b0, 1'b0}},
    '{'{16'hFFFF, 1'b0, 1'b1, 1'b0}, 1'b1, '{16'd1, 1'b0, 1'b0}},
    '{'{16'hFFFF, 1'b1, 1'b1, 1'b0}, 1'b1, '{16'd1, 1'b0, 1'b0}},
    '{'{16'h0000, 1'b0, 1'b1, 1'b0}, 1'b1, '{16'd1, 1'b0, 1'b0}},
    '{'{16'h00A5, 1'b0, 1'b1, 1'b0}, 1'b1, '{16'd1, 1'b0, 1'b0}},
    '{'{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b1, '{16'd2, 1'b0, 1'b0}},
    '{'{16'h1234, 1'b0, 1'b1, 1'b0}, 1'b1, '{16'd2, 1'b0, 1'b0}},
    '{'{16'h4321, 1'b1, 1'b1, 1'b0}, 1'b1, '{16'd3, 1'b0, 1'b0}},
    '{'{16'hAAAA, 1'b1, 1'b0, 1'b1}, 1'b1, '{16'd4, 1'b1, 1'b0}},
    '{'{16'h8000, 1'b0, 1'b1, 1'b1}, 1'b1, '{16'd1, 1'b1, 1'b0}},
    '{'{16'h8000, 1'b1, 1'b1, 1'b1}, 1'b1, '{16'd1, 1'b1, 1'b0}},
    '{'{16'h7FFF, 1'b0, 1'b1, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h5555, 1'b0, 1'b1, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h5555, 1'b1, 1'b1, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h1111, 1'b1, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h7FFF, 1'b1, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h0000, 1'b0, 1'b0, 1'b1}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h0001, 1'b0, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h0002, 1'b0, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h0003, 1'b1, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h0001, 1'b1, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{16'h0000, 1'b0, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0, 1'b0}}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [CodeBits-1:0]  s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CountBits-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  tag_nesting_conflict_counter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  tag_t        open_tags [StackDepth];
  int unsigned open_depth;
  int unsigned conflict_total;

  tag_result_t pending_counts [$];
  int          n_errors;
  int          idle_pct;
  int          stall_pct;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

  function automatic void add_conflicts(int unsigned n);
    if (conflict_total + n > CountMax) begin
      conflict_total = CountMax;
    end else begin
      conflict_total = conflict_total + n;
    end
  endfunction

  // Advance the stack model by one beat and return the result it causes.
  function automatic tag_result_t nest_step(tag_beat_t b);
    tag_result_t r;
    tag_t        tag;
    tag = b.code[TagBits-1:0];
    r = '0;
    if (b.valid) begin
      if (b.closing) begin
        if (open_depth == 0) begin
          add_conflicts(1);
        end else if (open_tags[open_depth-1] == tag) begin
          open_depth = open_depth - 1;
        end else begin
          add_conflicts(1);
          if (open_depth > 1 && open_tags[open_depth-2] == tag) begin
            open_depth = open_depth - 2;
          end
        end
      end else if (open_depth < StackDepth) begin
        open_tags[open_depth] = tag;
        open_depth = open_depth + 1;
      end else begin
        add_conflicts(1);
        r.ovf = 1'b1;
      end
    end
    if (b.last) begin
      add_conflicts(open_depth);
      r.done = 1'b1;
    end
    r.count = count_t'(conflict_total);
    if (b.last) begin
      open_depth = 0;
      conflict_total = 0;
    end
    return r;
  endfunction

  task automatic send_tag(input tag_beat_t b, input logic fixed, input tag_result_t fixed_res);
    tag_result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b.code;
    s_axis_tuser  <= {b.valid, b.closing};
    s_axis_tlast  <= b.last;
    do @(posedge clk_i); while (!s_axis_tready);
    r = nest_step(b);
    pending_counts.insert(pending_counts.size(), fixed ? fixed_res : r);
    @(negedge clk_i);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [CodeBits-1:0] pick_code();
    if ($urandom_range(0, 1) == 1) begin
      return CodeBits'($urandom_range(0, 7));
    end
    return CodeBits'($urandom_range(0, 65535));
  endfunction

  // Random documents: mostly well nested, with stray closes and bare markers.
  task automatic send_documents(input int n_items);
    int        sent;
    int        len;
    int        r;
    logic      fill;
    tag_beat_t b;
    sent = 0;
    while (sent < n_items) begin
      fill = ($urandom_range(0, 9) == 0);
      len  = fill ? StackDepth + 8 : $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        if (fill) begin
          r = ($urandom_range(0, 99) < 92) ? 0 : $urandom_range(38, 99);
        end else begin
          r = $urandom_range(0, 99);
        end
        b.code    = pick_code();
        b.valid   = 1'b1;
        b.closing = 1'b0;
        b.last    = (i == len - 1);
        if (r < 38) begin
          b.closing = 1'b0;
        end else if (r < 72 && open_depth > 0) begin
          b.closing = 1'b1;
          b.code    = CodeBits'(open_tags[open_depth-1]);
        end else if (r < 80 && open_depth > 1) begin
          b.closing = 1'b1;
          b.code    = CodeBits'(open_tags[open_depth-2]);
        end else if (r < 90) begin
          b.closing = 1'b1;
        end else begin
          b.valid   = 1'b0;
          b.closing = 1'($urandom_range(0, 1));
        end
        send_tag(b, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    tag_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat: count %0d done %0b ovf %0b", $realtime,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = pending_counts.pop_front();
        if (m_axis_tdata !== want.count) begin
          n_errors++;
          $display("%0t: conflict_count expected %0d actual %0d", $realtime, want.count,
                   m_axis_tdata);
        end
        if (m_axis_tlast !== want.done) begin
          n_errors++;
          $display("%0t: done_res expected %0b actual %0b", $realtime, want.done,
                   m_axis_tlast);
        end
        if (m_axis_tuser !== want.ovf) begin
          n_errors++;
          $display("%0t: overflow expected %0b actual %0b", $realtime, want.ovf,
                   m_axis_tuser);
        end
      end
    end
  end

  initial begin
    int waited;
    rst_ni         <= 1'b0;
    n_errors       = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    open_depth     = 0;
    conflict_total = 0;
    foreach (open_tags[i]) open_tags[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      if (phase == 0) begin
        for (int i = 0; i < NumDirRows; i++) begin
          send_tag(DirRows[i].beat, DirRows[i].fixed, DirRows[i].res);
        end
      end
      send_documents(125);
      drain_results();
    end

    waited = 0;
    while (pending_counts.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_counts.size() != 0) begin
      n_errors++;
      $display("%0t: %0d results never arrived, next expected count %0d", $realtime,
               pending_counts.size(), pending_counts[0].count);
    end
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
